/* rtl/core/pcss_pkg.sv */
`timescale 1ns / 1ps

package pcss_pkg;

    // Widths of the fields on the streaming ports.
    localparam int SAMPLE_W   = 16;
    localparam int CH_OUT_W   = 5;
    localparam int MEAN_W     = 16;
    localparam int STD_W      = 15;
    localparam int PEAK_W     = 15;
    localparam int FRAC_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int OUT_BITS   = CH_OUT_W + MEAN_W + STD_W + PEAK_W + FRAC_W + STATUS_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int            PADDR_W       = 3;
    localparam int            PDATA_W       = 32;
    localparam logic [2:0]    ADDR_THRESH   = 3'd0;
    localparam logic [15:0]   THRESH_RESET  = 16'sd410;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_RAGGED   = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // Integer square root of a 31-bit value, two bits per step.
    localparam int          SQRT_STEPS    = 16;
    localparam logic [31:0] SQRT_BIT_INIT = 32'h4000_0000;
    localparam logic [14:0] STD_MAX       = 15'h7FFF;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_FIN_RD,
        ST_FIN_LOAD,
        ST_DIV,
        ST_VAR,
        ST_SQ_INIT,
        ST_SQRT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        DIV_SUM,
        DIV_SQ,
        DIV_ACT
    } div_op_t;

endpackage

/* rtl/core/pcss_ram.sv */
`timescale 1ns / 1ps

module pcss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/per_channel_sequence_statistics.sv */
`timescale 1ns / 1ps

// Per-channel sequence statistics.
//
// Input words arrive on the s_axis channel in frame-major order: one signed
// Q4.12 sample in tdata, tlast on the final sample of the whole sequence.
// The channel of each sample follows from an internal position counter.
// On acceptance the channel's entry is read from the statistics RAM; in the
// update state it is updated and written back while no input is taken.
// After the word with tlast is folded in, the block emits NUM_CHANNELS
// result words on m_axis in channel order, tlast on the last channel. Each
// result is computed with a shared bit-serial divider (three divisions of
// 31+FW steps each, FW = clog2(MAX_FRAMES+1)) and a 16-step square root.
// During that burst no input is taken. The output register lets the next
// channel's work go on while a result waits, so a stalled receiver only
// stops the block when a second result is ready. Each entry is zeroed as
// its result is emitted. After reset the block sweeps every RAM entry to
// zero before it accepts input; the APB threshold register is writable
// at once.
module per_channel_sequence_statistics
    import pcss_pkg::*;
#(
    parameter int NUM_CHANNELS = 20,
    parameter int MAX_FRAMES   = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // APB register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    // Sample stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // sample_value
    input  logic                  s_axis_tlast,   // last_sample
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // channel_index, mean_value, std_value, peak_value, active_fraction,
    // status, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast    // last_result
);

    localparam int AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int FW   = $clog2(MAX_FRAMES + 1);
    localparam int SW   = SAMPLE_W + FW;
    localparam int SQW  = 31 + FW;
    localparam int EW   = SW + SQW + PEAK_W + FW;
    localparam int DCW  = $clog2(SQW + 1);
    localparam logic [AW-1:0] LAST_CH    = AW'(NUM_CHANNELS - 1);
    localparam logic [FW-1:0] FRAMES_MAX = FW'(MAX_FRAMES);

    state_t  state_reg, state_next;

    logic signed [15:0] thresh_reg;
    logic [AW-1:0]      pos_reg;
    logic [FW-1:0]      frame_reg;
    logic               ovf_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [AW-1:0]      fin_ch_reg;
    logic signed [15:0] samp_reg;
    logic               last_reg;

    logic [FW-1:0]      nf_reg;
    logic [1:0]         status_reg;

    // Working copy of one entry during the result burst.
    logic signed [SW-1:0] w_sum_reg;
    logic [SQW-1:0]       w_sq_reg;
    logic [PEAK_W-1:0]    w_peak_reg;
    logic [FW-1:0]        w_act_reg;

    // Shared restoring divider.
    div_op_t           div_op_reg;
    logic [SQW-1:0]    div_num_reg;
    logic [FW-1:0]     div_rem_reg;
    logic [DCW-1:0]    div_cnt_reg;

    logic signed [15:0] mean_reg;
    logic [30:0]        ex2_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [30:0]        msq_reg;

    logic [31:0]        sq_x_reg;
    logic [31:0]        sq_root_reg;
    logic [31:0]        sq_bit_reg;
    logic [4:0]         sq_cnt_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    // RAM port signals.
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [EW-1:0]  ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [EW-1:0]  ram_rdata;

    logic signed [SW-1:0] rd_sum;
    logic [SQW-1:0]       rd_sq;
    logic [PEAK_W-1:0]    rd_peak;
    logic [FW-1:0]        rd_act;

    logic                 accept;
    logic                 skip;
    logic signed [31:0]   samp_prod;
    logic signed [SW-1:0] upd_sum;
    logic [SQW-1:0]       upd_sq;
    logic [PEAK_W-1:0]    upd_peak;
    logic [FW-1:0]        upd_act;
    logic [EW-1:0]        upd_entry;

    logic [FW:0]          div_trial;
    logic                 div_ge;
    logic [SQW-1:0]       div_q_new;
    logic [FW-1:0]        div_rem_new;
    logic                 div_done;
    logic [16:0]          mean_mag;

    logic signed [31:0]   var_val;
    logic [31:0]          sq_trial;
    logic                 sq_ge;
    logic [14:0]          std_val;
    logic                 out_free;
    logic [FW-1:0]        nf_calc;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign skip   = (pos_reg == '0) && (frame_reg >= FRAMES_MAX);

    assign {rd_sum, rd_sq, rd_peak, rd_act} = ram_rdata;

    // Accumulate one sample into the entry just read.
    assign samp_prod = samp_reg * samp_reg;
    assign upd_sum   = rd_sum + SW'(samp_reg);
    assign upd_sq    = rd_sq + SQW'($unsigned(samp_prod));
    assign upd_peak  = (samp_reg > $signed({1'b0, rd_peak})) ? samp_reg[14:0] : rd_peak;
    assign upd_act   = rd_act + FW'(samp_reg >= thresh_reg);
    assign upd_entry = {upd_sum, upd_sq, upd_peak, upd_act};

    // One step of long division by the frame count.
    assign div_trial   = {div_rem_reg, div_num_reg[SQW-1]};
    assign div_ge      = div_trial >= {1'b0, nf_reg};
    assign div_rem_new = div_ge ? FW'(div_trial - {1'b0, nf_reg}) : div_trial[FW-1:0];
    assign div_q_new   = {div_num_reg[SQW-2:0], div_ge};
    assign div_done    = (div_cnt_reg == DCW'(1));
    assign mean_mag    = div_q_new[16:0];

    assign var_val  = $signed({1'b0, ex2_reg}) - $signed({1'b0, msq_reg});
    assign sq_trial = sq_root_reg + sq_bit_reg;
    assign sq_ge    = sq_x_reg >= sq_trial;
    assign std_val  = (sq_root_reg > 32'(STD_MAX)) ? STD_MAX : sq_root_reg[14:0];

    assign out_free = !out_valid_reg || m_axis_tready;
    assign nf_calc  = ((frame_reg == '0) && (pos_reg == '0)) ? FW'(1)
                    : frame_reg + FW'(pos_reg != '0);

    pcss_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_CHANNELS)
    ) u_stats_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state and RAM control.
    always_comb
    begin
        state_next    = state_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg;
        ram_wdata     = '0;
        ram_raddr     = pos_reg;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                if (clr_addr_reg == LAST_CH)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ram_we    = !skip;
                ram_wdata = upd_entry;
                state_next = last_reg ? ST_FIN_RD : ST_IDLE;
            end
            ST_FIN_RD:
            begin
                ram_raddr  = fin_ch_reg;
                state_next = ST_FIN_LOAD;
            end
            ST_FIN_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done && (div_op_reg == DIV_ACT))
                begin
                    state_next = ST_VAR;
                end
            end
            ST_VAR:
            begin
                state_next = ST_SQ_INIT;
            end
            ST_SQ_INIT:
            begin
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sq_cnt_reg == 5'd1)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = fin_ch_reg;
                    state_next = (fin_ch_reg == LAST_CH) ? ST_IDLE : ST_FIN_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control counters, the output valid flag and the configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= THRESH_RESET;
            pos_reg       <= '0;
            frame_reg     <= '0;
            ovf_reg       <= 1'b0;
            clr_addr_reg  <= '0;
            fin_ch_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && (paddr == ADDR_THRESH))
            begin
                thresh_reg <= pwdata[15:0];
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (state_reg == ST_UPDATE)
            begin
                if (skip)
                begin
                    ovf_reg <= 1'b1;
                end
                else if (pos_reg == LAST_CH)
                begin
                    pos_reg   <= '0;
                    frame_reg <= frame_reg + FW'(1);
                end
                else
                begin
                    pos_reg <= pos_reg + AW'(1);
                end
            end
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (fin_ch_reg == LAST_CH)
                begin
                    fin_ch_reg <= '0;
                    pos_reg    <= '0;
                    frame_reg  <= '0;
                    ovf_reg    <= 1'b0;
                end
                else
                begin
                    fin_ch_reg <= fin_ch_reg + AW'(1);
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
        case (state_reg)
            ST_FIN_RD:
            begin
                nf_reg     <= nf_calc;
                status_reg <= ovf_reg ? STATUS_OVERFLOW
                            : ((pos_reg != '0) ? STATUS_RAGGED : STATUS_OK);
            end
            ST_FIN_LOAD:
            begin
                w_sum_reg   <= rd_sum;
                w_sq_reg    <= rd_sq;
                w_peak_reg  <= rd_peak;
                w_act_reg   <= rd_act;
                div_op_reg  <= DIV_SUM;
                div_num_reg <= SQW'(rd_sum[SW-1] ? SW'(-rd_sum) : SW'(rd_sum));
                div_rem_reg <= '0;
                div_cnt_reg <= DCW'(SQW);
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    div_rem_reg <= '0;
                    div_cnt_reg <= DCW'(SQW);
                    case (div_op_reg)
                        DIV_SUM:
                        begin
                            mean_reg    <= w_sum_reg[SW-1] ? 16'(-mean_mag) : mean_mag[15:0];
                            div_op_reg  <= DIV_SQ;
                            div_num_reg <= w_sq_reg;
                        end
                        DIV_SQ:
                        begin
                            ex2_reg     <= div_q_new[30:0];
                            div_op_reg  <= DIV_ACT;
                            div_num_reg <= SQW'({w_act_reg, 15'd0});
                        end
                        default:
                        begin
                            frac_reg <= div_q_new[FRAC_W-1:0];
                        end
                    endcase
                end
                else
                begin
                    div_num_reg <= div_q_new;
                    div_rem_reg <= div_rem_new;
                    div_cnt_reg <= div_cnt_reg - DCW'(1);
                end
            end
            ST_VAR:
            begin
                msq_reg <= 31'($unsigned(32'(mean_reg) * 32'(mean_reg)));
            end
            ST_SQ_INIT:
            begin
                sq_x_reg    <= (var_val > 0) ? $unsigned(var_val) : 32'd0;
                sq_root_reg <= '0;
                sq_bit_reg  <= SQRT_BIT_INIT;
                sq_cnt_reg  <= 5'(SQRT_STEPS);
            end
            ST_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_x_reg    <= sq_x_reg - sq_trial;
                    sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_root_reg <= sq_root_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                sq_cnt_reg <= sq_cnt_reg - 5'd1;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_data_reg <= OUT_DATA_W'({status_reg, frac_reg, w_peak_reg,
                                                 std_val, mean_reg, CH_OUT_W'(fin_ch_reg)});
                    out_last_reg <= (fin_ch_reg == LAST_CH);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_THRESH) ? PDATA_W'(thresh_reg) : '0;

    // The position counter never leaves the channel range.
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= LAST_CH)
        else $error("channel position out of range");

    // Frames never count past the limit.
    assert property (@(posedge clk) disable iff (!rst_n) frame_reg <= FRAMES_MAX)
        else $error("frame count past limit");

    // An update cycle always follows an accepted sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> $past(accept))
        else $error("update without accepted sample");

    // The divider never sees a zero frame count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (nf_reg != '0))
        else $error("division by zero frame count");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

// Holds a copy of the per-channel accumulators and predicts the statistics
// words that the block emits at the end of each sequence.
class stats_scoreboard;
    localparam int CHANNELS = 20;
    localparam int FRAME_LIMIT = 4096;

    longint sum_acc [CHANNELS];
    longint unsigned sq_acc [CHANNELS];
    int peak_acc [CHANNELS];
    int active_acc [CHANNELS];
    int frames;
    int position;
    bit frame_overflow;
    int threshold;
    logic [68:0] pending_stats [$];
    int errors;

    function new();
        threshold = 410;
        errors = 0;
        clear();
    endfunction

    function void clear();
        for (int c = 0; c < CHANNELS; c++)
        begin
            sum_acc[c] = 0;
            sq_acc[c] = 0;
            peak_acc[c] = 0;
            active_acc[c] = 0;
        end
        frames = 0;
        position = 0;
        frame_overflow = 0;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Folds one accepted sample in; on the final sample queues one word per channel.
    function void note_sample(logic signed [15:0] value, bit last);
        int v;
        longint nf;
        longint mean;
        longint ex2;
        longint var_est;
        longint unsigned sd;
        longint unsigned frac;
        logic [1:0] status;
        v = value;
        if (position == 0 && frames >= FRAME_LIMIT)
            frame_overflow = 1;
        else
        begin
            sum_acc[position] += v;
            sq_acc[position] += longint'(v) * longint'(v);
            if (v > peak_acc[position])
                peak_acc[position] = v;
            if (v >= threshold)
                active_acc[position]++;
            position++;
            if (position >= CHANNELS)
            begin
                position = 0;
                frames++;
            end
        end
        if (!last)
            return;
        nf = frames + (position != 0 ? 1 : 0);
        if (nf == 0)
            nf = 1;
        status = frame_overflow ? pcss_pkg::STATUS_OVERFLOW
               : (position != 0 ? pcss_pkg::STATUS_RAGGED : pcss_pkg::STATUS_OK);
        for (int c = 0; c < CHANNELS; c++)
        begin
            mean = sum_acc[c] / nf;
            ex2 = longint'(sq_acc[c] / longint'(nf));
            var_est = ex2 - mean * mean;
            sd = var_est > 0 ? floor_sqrt(var_est) : 0;
            if (sd > 32767)
                sd = 32767;
            frac = (longint'(active_acc[c]) << 15) / nf;
            pending_stats.push_back({status, frac[15:0], peak_acc[c][14:0], sd[14:0],
                                     mean[15:0], c[4:0]});
        end
        clear();
    endfunction

    function void check_result(logic [71:0] data, bit last);
        logic [68:0] exp_word;
        bit exp_last;
        if (pending_stats.size() == 0)
        begin
            $display("%0t: unexpected result word %h", $time, data);
            errors++;
            return;
        end
        exp_word = pending_stats.pop_front();
        exp_last = exp_word[4:0] == CHANNELS - 1;
        if (data[4:0] != exp_word[4:0])
            report("channel_index", exp_word[4:0], data[4:0]);
        if (data[20:5] != exp_word[20:5])
            report("mean_value", exp_word[20:5], data[20:5]);
        if (data[35:21] != exp_word[35:21])
            report("std_value", exp_word[35:21], data[35:21]);
        if (data[50:36] != exp_word[50:36])
            report("peak_value", exp_word[50:36], data[50:36]);
        if (data[66:51] != exp_word[66:51])
            report("active_fraction", exp_word[66:51], data[66:51]);
        if (data[68:67] != exp_word[68:67])
            report("status", exp_word[68:67], data[68:67]);
        if (data[71:69] != 3'b0)
            report("zero fill", 0, data[71:69]);
        if (last != exp_last)
            report("last_result", exp_last, last);
    endfunction

    function void report(string field, longint unsigned exp_val, longint unsigned act_val);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
        errors++;
    endfunction
endclass

module testbench;
    import pcss_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata = '0;    // sample_value
    logic s_axis_tlast = 0;                    // last_sample
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    // channel_index, mean_value, std_value, peak_value, active_fraction, status, fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;                        // last_result

    // While set, neither side inserts gaps or stalls.
    bit steady = 0;
    stats_scoreboard stats = new();

    per_channel_sequence_statistics uut (.*);

    always #6 clk = ~clk;

    // Results are checked with the values sampled at the edge, and the receiver
    // then decides whether to stall on the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            stats.check_result(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= steady || ($urandom_range(99) >= 28);
    end

    task automatic write_threshold(logic signed [15:0] value);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ADDR_THRESH;
        pwdata <= {{16{value[15]}}, value};
        @(posedge clk);
        penable <= 1;
        // The register takes the value at the edge ending the access cycle.
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        stats.threshold = value;
    endtask

    // Offers one word, sometimes with a random gap ahead of it.
    task automatic send_sample(logic signed [15:0] value, bit last);
        if (!steady && $urandom_range(99) < 28)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= value;
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        stats.note_sample(value, last);
    endtask

    // Lets the statistics burst drain before the next register write.
    task automatic drain();
        s_axis_tvalid <= 0;
        s_axis_tlast <= 0;
        while (stats.pending_stats.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 800));
            3: return 16'(stats.threshold + $signed($urandom_range(0, 2)) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_sequences(int count);
        int len;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            // Mostly whole frames, sometimes a ragged tail.
            len = 20 * $urandom_range(1, 3);
            if ($urandom_range(3) == 0)
                len = $urandom_range(1, 59);
            if (len > count - sent)
                len = count - sent;
            for (int i = 0; i < len; i++)
                send_sample(random_sample(), i == len - 1);
            sent += len;
        end
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;

        // Directed part at the reset threshold: a one-sample ragged sequence,
        // then one full frame with the extremes and values around the threshold.
        send_sample(16'sh7FFF, 1);
        for (int i = 0; i < 20; i++)
            send_sample(i == 0 ? 16'sh8000 : i == 1 ? 16'sh7FFF : i == 2 ? 16'sd410 :
                        i == 3 ? 16'sd409 : i == 4 ? 16'sh0000 : 16'shFFFF, i == 19);
        drain();

        // A stretch of 30 samples at full rate on both sides.
        write_threshold(16'sh8000);
        steady = 1;
        random_sequences(30);
        steady = 0;
        write_threshold(16'sh7FFF);
        for (int i = 0; i < 20; i++)
            send_sample(16'sh7FFF, i == 19);
        random_sequences(20);
        write_threshold(16'($urandom_range(0, 1000)));
        random_sequences(40);

        if (stats.errors == 0)
            $display("[per_channel_sequence_statistics] OK");
        else
            $display("[per_channel_sequence_statistics] ERROR");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("[per_channel_sequence_statistics] ERROR");
        $finish;
    end
endmodule

/* files.f */
rtl/core/pcss_pkg.sv
rtl/core/pcss_ram.sv
rtl/core/per_channel_sequence_statistics.sv
bench/testbench.sv
